@@ rtl/pgbh_pkg.sv @@
`default_nettype none
package pgbh_pkg;

    localparam int COORD_BITS  = 20;
    localparam int COUNT_BITS  = 16;
    // grid side must stay a power of two: the row and column wrap is a bit slice
    localparam int GRID_SIDE   = 64;
    localparam int SIDE_BITS   = $clog2(GRID_SIDE);
    localparam int ADDR_BITS   = 2 * SIDE_BITS;
    localparam int SHIFT_BITS  = 5;
    localparam int CUT_BITS    = 9;
    localparam int CUT_SHIFT   = 8;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = COORD_BITS;
    localparam int ACT_BITS    = 2;
    localparam int STATUS_BITS = 3;

    localparam int SPAN_BITS   = COORD_BITS + 1;
    localparam int PROD_BITS   = SPAN_BITS + CUT_BITS;
    localparam int THR_BITS    = PROD_BITS - CUT_SHIFT + 2;

    localparam int IN_FIELD_BITS  = 3 * COORD_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 2 * SIDE_BITS + COUNT_BITS + 2 * COORD_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam int OUT_COL_LSB  = SIDE_BITS;
    localparam int OUT_SLOT_LSB = 2 * SIDE_BITS;
    localparam int OUT_LOW_LSB  = OUT_SLOT_LSB + COUNT_BITS;
    localparam int OUT_HIGH_LSB = OUT_LOW_LSB + COORD_BITS;

    localparam logic [CUT_BITS-1:0] CUT_ONE = CUT_BITS'(256);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_X_LOW  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_X_HIGH = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Y_LOW  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Y_HIGH = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Z_LOW  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Z_HIGH = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SHIFT  = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CUT    = 3'd7;

    typedef enum logic [ACT_BITS-1:0] {
        ACT_CLEAR    = 2'd0,
        ACT_BIN      = 2'd1,
        ACT_CLASSIFY = 2'd2,
        ACT_NONE     = 2'd3
    } t_action;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_BINNED   = 3'd0,
        ST_REJECTED = 3'd1,
        ST_KEPT     = 3'd2,
        ST_DROPPED  = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_CLEARED  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_LOC,
        S_READ,
        S_EVAL,
        S_CLR
    } t_state;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x_low;
        logic signed [COORD_BITS-1:0] x_high;
        logic signed [COORD_BITS-1:0] y_low;
        logic signed [COORD_BITS-1:0] y_high;
        logic signed [COORD_BITS-1:0] z_low;
        logic signed [COORD_BITS-1:0] z_high;
        logic [SHIFT_BITS-1:0]        shift;
        logic [CUT_BITS-1:0]          cut;
    } t_cfg;

    typedef struct packed {
        logic                 reject;
        logic [SIDE_BITS-1:0] row;
        logic [SIDE_BITS-1:0] col;
    } t_loc;

    typedef struct packed {
        logic [COUNT_BITS-1:0]        count;
        logic signed [COORD_BITS-1:0] low_z;
        logic signed [COORD_BITS-1:0] high_z;
    } t_cell;

    localparam int CELL_BITS = $bits(t_cell);

    typedef struct packed {
        logic [COUNT_BITS-1:0]        count;
        logic signed [COORD_BITS-1:0] low_z;
        logic signed [COORD_BITS-1:0] high_z;
        logic                         keep;
    } t_upd;

    typedef struct packed {
        t_status                      status;
        logic [SIDE_BITS-1:0]         row;
        logic [SIDE_BITS-1:0]         col;
        logic [COUNT_BITS-1:0]        slot;
        logic signed [COORD_BITS-1:0] low_z;
        logic signed [COORD_BITS-1:0] high_z;
    } t_result;

endpackage
`default_nettype wire

@@ rtl/pgbh_cell_ram.sv @@
`default_nettype none
module pgbh_cell_ram #(
    parameter int ADDR_BITS = 12,
    parameter int DATA_BITS = 56
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [DATA_BITS-1:0] i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ rtl/pgbh_locate.sv @@
`default_nettype none
module pgbh_locate (
    input  pgbh_pkg::t_cfg                       i_cfg,
    input  logic signed [pgbh_pkg::COORD_BITS-1:0] i_x,
    input  logic signed [pgbh_pkg::COORD_BITS-1:0] i_y,
    input  logic signed [pgbh_pkg::COORD_BITS-1:0] i_z,
    output pgbh_pkg::t_loc                       o_loc
);
    import pgbh_pkg::*;

    logic signed [COORD_BITS:0] ox;
    logic signed [COORD_BITS:0] oy;
    logic [COORD_BITS:0]        ox_sh;
    logic [COORD_BITS:0]        oy_sh;
    logic                       out_box;
    logic                       has_zero;

    always_comb begin
        ox = $signed({i_x[COORD_BITS-1], i_x})
             + $signed({i_cfg.x_high[COORD_BITS-1], i_cfg.x_high});
        oy = $signed({i_y[COORD_BITS-1], i_y})
             + $signed({i_cfg.y_high[COORD_BITS-1], i_cfg.y_high});
        has_zero = (i_x == '0) || (i_y == '0) || (i_z == '0);
        out_box = ($signed(i_x) < $signed(i_cfg.x_low)) || ($signed(i_x) > $signed(i_cfg.x_high))
               || ($signed(i_y) < $signed(i_cfg.y_low)) || ($signed(i_y) > $signed(i_cfg.y_high))
               || ($signed(i_z) < $signed(i_cfg.z_low)) || ($signed(i_z) > $signed(i_cfg.z_high));
        // offsets are non-negative whenever the point is kept
        ox_sh = $unsigned(ox) >> i_cfg.shift;
        oy_sh = $unsigned(oy) >> i_cfg.shift;
        o_loc.reject = has_zero || out_box || ox[COORD_BITS] || oy[COORD_BITS];
        o_loc.row    = ox_sh[SIDE_BITS-1:0];
        o_loc.col    = oy_sh[SIDE_BITS-1:0];
    end

endmodule
`default_nettype wire

@@ rtl/pgbh_update.sv @@
`default_nettype none
module pgbh_update (
    input  logic                                 i_clk,
    input  logic                                 i_load,
    input  logic                                 i_bin,
    input  pgbh_pkg::t_cell                      i_rd,
    input  logic signed [pgbh_pkg::COORD_BITS-1:0] i_z,
    input  logic [pgbh_pkg::CUT_BITS-1:0]        i_cut,
    output pgbh_pkg::t_cell                      o_wr,
    output pgbh_pkg::t_upd                       o_upd
);
    import pgbh_pkg::*;

    logic signed [COORD_BITS-1:0] new_low;
    logic signed [COORD_BITS-1:0] new_high;
    logic [SPAN_BITS-1:0]         span;
    logic [CUT_BITS-1:0]          cut_eff;
    logic [COUNT_BITS-1:0]        r_count;
    logic signed [COORD_BITS-1:0] r_low;
    logic signed [COORD_BITS-1:0] r_high;
    logic signed [COORD_BITS-1:0] r_z;
    logic [PROD_BITS-1:0]         r_prod;
    logic signed [THR_BITS-1:0]   thr;
    logic signed [THR_BITS-1:0]   z_ext;

    always_comb begin
        if (i_rd.count == '0) begin
            new_low  = i_z;
            new_high = i_z;
        end else begin
            new_low  = ($signed(i_z) < $signed(i_rd.low_z))  ? i_z : i_rd.low_z;
            new_high = ($signed(i_z) > $signed(i_rd.high_z)) ? i_z : i_rd.high_z;
        end
        o_wr.count  = (i_rd.count == COUNT_MAX) ? i_rd.count : i_rd.count + 1'b1;
        o_wr.low_z  = new_low;
        o_wr.high_z = new_high;
        span    = SPAN_BITS'($signed({i_rd.high_z[COORD_BITS-1], i_rd.high_z})
                            - $signed({i_rd.low_z[COORD_BITS-1], i_rd.low_z}));
        cut_eff = (i_cut > CUT_ONE) ? CUT_ONE : i_cut;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_count <= i_rd.count;
            r_low   <= i_bin ? new_low  : i_rd.low_z;
            r_high  <= i_bin ? new_high : i_rd.high_z;
            r_z     <= i_z;
            r_prod  <= PROD_BITS'(span) * PROD_BITS'(cut_eff);
        end
    end

    always_comb begin
        thr   = THR_BITS'(r_low) + $signed(THR_BITS'(r_prod[PROD_BITS-1:CUT_SHIFT]));
        z_ext = THR_BITS'(r_z);
        o_upd.count  = r_count;
        o_upd.low_z  = r_low;
        o_upd.high_z = r_high;
        o_upd.keep   = (z_ext >= thr);
    end

endmodule
`default_nettype wire

@@ rtl/point_grid_bin_height_filter_top.sv @@
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tuser: action; tdata: point_x, point_y, point_z
// m_axis    out  m_axis_tvalid/m_axis_tready    tuser: status; tdata: row, col, slot, low z, high z
// cfg       in   i_cfg_we                       i_cfg_addr register index, i_cfg_data value
//
// Bin and classify pass through accept, locate + cell read, update (+ write-back for bin)
// and result; a rejected point skips the update. The steps follow from the read-modify-write
// of the cell RAM and its registered read.
// Clear walks the 4096 cells one per cycle.
// After reset the same sweep of the 4096 cells runs before s_axis_tready rises.
// The result register lets the next item in while a result waits; a result that cannot
// leave holds the engine in its final step.
`default_nettype none
module point_grid_bin_height_filter_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [19:0] point_x, [39:20] point_y, [59:40] point_z, [63:60] zero
    input  logic [pgbh_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
    // [1:0] action
    input  logic [pgbh_pkg::ACT_BITS-1:0]         s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [5:0] cell_row, [11:6] cell_col, [27:12] slot_index, [47:28] cell_low_z,
    // [67:48] cell_high_z, [71:68] zero
    output logic [pgbh_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
    // [2:0] status
    output logic [pgbh_pkg::STATUS_BITS-1:0]      m_axis_tuser,
    input  logic                                  i_cfg_we,
    input  logic [pgbh_pkg::CFG_IDX_BITS-1:0]     i_cfg_addr,
    input  logic [pgbh_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    import pgbh_pkg::*;

    t_cfg                         r_cfg;
    t_state                       r_state;
    t_state                       n_state;
    logic [ADDR_BITS-1:0]         r_sweep;
    logic [ADDR_BITS-1:0]         n_sweep;
    t_action                      r_act;
    logic signed [COORD_BITS-1:0] r_x;
    logic signed [COORD_BITS-1:0] r_y;
    logic signed [COORD_BITS-1:0] r_z;
    t_loc                         r_loc;
    logic                         r_reject;
    logic                         n_reject;
    logic                         r_out_valid;
    t_result                      r_out;
    t_result                      res;

    t_loc                         loc;
    t_cell                        rd_cell;
    t_cell                        wr_cell;
    t_upd                         upd;
    logic [CELL_BITS-1:0]         rd_word;
    logic                         mem_we;
    logic [ADDR_BITS-1:0]         mem_waddr;
    logic [CELL_BITS-1:0]         mem_wdata;
    logic                         mem_re;
    logic                         accept;
    logic                         out_free;
    logic                         load_out;
    logic                         upd_load;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_low  <= COORD_BITS'(-12800);
            r_cfg.x_high <= COORD_BITS'(12800);
            r_cfg.y_low  <= COORD_BITS'(-12800);
            r_cfg.y_high <= COORD_BITS'(12800);
            r_cfg.z_low  <= COORD_BITS'(-768);
            r_cfg.z_high <= COORD_BITS'(2560);
            r_cfg.shift  <= SHIFT_BITS'(9);
            r_cfg.cut    <= CUT_BITS'(128);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_X_LOW:  r_cfg.x_low  <= i_cfg_data;
                CFG_X_HIGH: r_cfg.x_high <= i_cfg_data;
                CFG_Y_LOW:  r_cfg.y_low  <= i_cfg_data;
                CFG_Y_HIGH: r_cfg.y_high <= i_cfg_data;
                CFG_Z_LOW:  r_cfg.z_low  <= i_cfg_data;
                CFG_Z_HIGH: r_cfg.z_high <= i_cfg_data;
                CFG_SHIFT:  r_cfg.shift  <= i_cfg_data[SHIFT_BITS-1:0];
                CFG_CUT:    r_cfg.cut    <= i_cfg_data[CUT_BITS-1:0];
                default: ;
            endcase
        end
    end

    pgbh_locate u_locate (
        .i_cfg (r_cfg),
        .i_x   (r_x),
        .i_y   (r_y),
        .i_z   (r_z),
        .o_loc (loc)
    );

    pgbh_cell_ram #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (CELL_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr ({loc.row, loc.col}),
        .o_rdata (rd_word)
    );

    assign rd_cell = t_cell'(rd_word);

    pgbh_update u_update (
        .i_clk  (i_clk),
        .i_load (upd_load),
        .i_bin  (r_act == ACT_BIN),
        .i_rd   (rd_cell),
        .i_z    (r_z),
        .i_cut  (r_cfg.cut),
        .o_wr   (wr_cell),
        .o_upd  (upd)
    );

    // result of the item in its final step
    always_comb begin
        res = '0;
        if (r_act == ACT_CLEAR) begin
            res.status = ST_CLEARED;
        end else if (r_reject) begin
            res.status = ST_REJECTED;
        end else if (r_act == ACT_BIN) begin
            res.status = ST_BINNED;
            res.row    = r_loc.row;
            res.col    = r_loc.col;
            res.slot   = upd.count;
            res.low_z  = upd.low_z;
            res.high_z = upd.high_z;
        end else if (upd.count == '0) begin
            res.status = ST_EMPTY;
            res.row    = r_loc.row;
            res.col    = r_loc.col;
        end else begin
            res.status = upd.keep ? ST_KEPT : ST_DROPPED;
            res.row    = r_loc.row;
            res.col    = r_loc.col;
            res.slot   = upd.count;
            res.low_z  = upd.low_z;
            res.high_z = upd.high_z;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_sweep       = r_sweep;
        n_reject      = r_reject;
        s_axis_tready = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = r_sweep;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        upd_load      = 1'b0;
        load_out      = 1'b0;
        case (r_state)
            S_INIT, S_CLR: begin
                // only the count field matters; stored heights are ignored at count zero
                mem_we  = 1'b1;
                n_sweep = r_sweep + 1'b1;
                if (&r_sweep) begin
                    n_state = (r_state == S_INIT) ? S_IDLE : S_EVAL;
                end
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (accept) begin
                    n_state = S_LOC;
                end
            end
            S_LOC: begin
                n_sweep = '0;
                if (r_act == ACT_CLEAR) begin
                    n_state = S_CLR;
                end else begin
                    n_reject = loc.reject || (r_act == ACT_NONE);
                    mem_re   = 1'b1;
                    n_state  = n_reject ? S_EVAL : S_READ;
                end
            end
            S_READ: begin
                upd_load  = 1'b1;
                mem_we    = (r_act == ACT_BIN);
                mem_waddr = {r_loc.row, r_loc.col};
                mem_wdata = wr_cell;
                n_state   = S_EVAL;
            end
            S_EVAL: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_sweep     <= '0;
            r_reject    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sweep  <= n_sweep;
            r_reject <= n_reject;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act <= t_action'(s_axis_tuser);
            r_x   <= s_axis_tdata[COORD_BITS-1:0];
            r_y   <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
            r_z   <= s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
        end
        if (r_state == S_LOC) begin
            r_loc <= loc;
        end
        if (load_out) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = OUT_DATA_BITS'({r_out.high_z, r_out.low_z, r_out.slot,
                                           r_out.col, r_out.row});

endmodule
`default_nettype wire

@@ rtl/pgbh_checker.sv @@
`default_nettype none
module pgbh_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [pgbh_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    input logic [pgbh_pkg::STATUS_BITS-1:0]    m_axis_tuser
);
    import pgbh_pkg::*;

    logic signed [COORD_BITS-1:0] out_low;
    logic signed [COORD_BITS-1:0] out_high;
    logic [COUNT_BITS-1:0]        out_slot;

    assign out_low  = m_axis_tdata[OUT_LOW_LSB +: COORD_BITS];
    assign out_high = m_axis_tdata[OUT_HIGH_LSB +: COORD_BITS];
    assign out_slot = m_axis_tdata[OUT_SLOT_LSB +: COUNT_BITS];

    // the cell sweep after reset keeps the input closed
    a_init_closed: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready && !m_axis_tvalid)
        else $error("input open or result valid right after reset");

    // one item at a time: the input closes right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input stayed open after an accepted item");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_blank_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_REJECTED || m_axis_tuser == ST_CLEARED)
        |-> m_axis_tdata == '0)
        else $error("rejected or cleared result carries data");

    a_classified: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_KEPT || m_axis_tuser == ST_DROPPED)
        |-> out_slot != '0 && out_low <= out_high)
        else $error("classified against an empty or inverted cell");

endmodule

bind point_grid_bin_height_filter_top pgbh_checker u_pgbh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
